FILE: design/chacha20_stream_cipher_assert.svh
// Assertion macros for the cipher's checker.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CC20_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cc20 check failed");

// Check a property on every clock edge, reset included.
`define CC20_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cc20 check failed");

`endif

FILE: design/cc20_pkg.sv
// Shared types, constants and functions of the ChaCha20 stream cipher.
`default_nettype none

package cc20_pkg;

  localparam int unsigned WordBits     = 32;
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned Lanes        = 4;
  localparam int unsigned DoubleRounds = 10;
  // Each round is split into two half quarter-round steps
  localparam int unsigned HalfSteps    = DoubleRounds * 4;
  localparam int unsigned StepW        = $clog2(HalfSteps);
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned CfgIdxW      = 3;

  localparam int unsigned RotA = 16;
  localparam int unsigned RotB = 12;
  localparam int unsigned RotC = 8;
  localparam int unsigned RotD = 7;

  localparam logic [2:0] CountFull = 3'd4;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [StepW-1:0]    step_t;
  typedef logic [QPtrW-1:0]    qptr_t;
  typedef logic [QPtrW:0]      qcnt_t;

  // Final half step of the round sequence
  localparam step_t LastStep = step_t'(HalfSteps - 1);

  localparam logic [3:0][WordBits-1:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY01   = 3'd0,
    REG_KEY23   = 3'd1,
    REG_KEY45   = 3'd2,
    REG_KEY67   = 3'd3,
    REG_NONCE01 = 3'd4,
    REG_NONCE2  = 3'd5,
    REG_START   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0][WordBits-1:0] key;
    logic [2:0][WordBits-1:0] nonce;
    word_t                    start_ctr;
  } cfg_t;

  // One classified message word on its way to the back end
  typedef struct packed {
    word_t      data;
    logic [2:0] count;
    logic       last;
    logic       new_msg;
    logic       new_block;
    logic [3:0] pos;
  } item_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr4_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINAL
  } bk_state_t;

  function automatic word_t rotl(word_t v, int unsigned r);
    return (v << r) | (v >> (WordBits - r));
  endfunction

  // First or second half of a quarter round
  function automatic qr4_t qr_half(qr4_t q, logic second);
    qr4_t o;
    o   = q;
    o.a = o.a + o.b;
    o.d = second ? rotl(o.d ^ o.a, RotC) : rotl(o.d ^ o.a, RotA);
    o.c = o.c + o.d;
    o.b = second ? rotl(o.b ^ o.c, RotD) : rotl(o.b ^ o.c, RotB);
    return o;
  endfunction

  // Lane mask of the valid bytes of a word
  function automatic word_t byte_mask(logic [2:0] cnt);
    word_t m;
    case (cnt)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // Word of the initial block state
  function automatic word_t init_word(cfg_t cfg, word_t ctr, logic [3:0] idx);
    logic [3:0] k;
    logic [3:0] n;
    word_t      w;
    k = idx - 4'd4;
    n = idx - 4'd13;
    if (idx < 4'd4) begin
      w = Sigma[idx[1:0]];
    end else if (idx < 4'd12) begin
      w = cfg.key[k[2:0]];
    end else if (idx == 4'd12) begin
      w = ctr;
    end else begin
      w = cfg.nonce[n[1:0]];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/chacha20_stream_cipher.sv
// Top level of the ChaCha20 stream cipher: configuration registers and the three stages.
// A word inside a keystream block passes through the queue and then the result register.
// A word that opens a block waits for generation: 40 half-round steps, the feed-forward
// step and then the result register; the shared round unit sets this.
// Throughput: one word per cycle within a block while the output is not stalled.
// Reset: synchronous, active low; clears control and config (start counter 1), not the store.
`default_nettype none

module chacha20_stream_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_word,
  output logic [2:0]       out_result_count,
  output logic             out_result_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cc20_pkg::cfg_t  cfg_r;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            q_valid;
  cc20_pkg::item_t push_item;
  cc20_pkg::item_t q_head;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{key: '0, nonce: '0, start_ctr: 32'd1};
    end else if (cfg_valid && cfg_ready) begin
      case (cc20_pkg::cfg_reg_t'(cfg_index))
        cc20_pkg::REG_KEY01:   cfg_r.key[1:0]   <= cfg_data;
        cc20_pkg::REG_KEY23:   cfg_r.key[3:2]   <= cfg_data;
        cc20_pkg::REG_KEY45:   cfg_r.key[5:4]   <= cfg_data;
        cc20_pkg::REG_KEY67:   cfg_r.key[7:6]   <= cfg_data;
        cc20_pkg::REG_NONCE01: cfg_r.nonce[1:0] <= cfg_data;
        cc20_pkg::REG_NONCE2:  cfg_r.nonce[2]   <= cfg_data[31:0];
        cc20_pkg::REG_START:   cfg_r.start_ctr  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  cc20_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  cc20_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_word  (out_result_word),
    .out_result_count (out_result_count),
    .out_result_last  (out_result_last)
  );

endmodule

`default_nettype wire

FILE: design/cc20_front.sv
// Front end: accepts message words, tracks message and block position.
`default_nettype none

module cc20_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [31:0]     in_data_word,
  input  wire logic [2:0]      in_byte_count,
  input  wire logic            in_last_word,
  input  wire logic            q_full,
  output logic                 push,
  output cc20_pkg::item_t      push_item
);

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  logic       in_msg_r;
  logic [3:0] cur_pos;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Restart position at a message start
  assign cur_pos = in_msg_r ? pos_r : 4'd0;
  assign pos_nxt = cur_pos + 4'd1;

  // Classify the word
  always_comb begin
    push_item.data      = in_data_word;
    push_item.count     = (in_byte_count == 3'd0 || in_byte_count > cc20_pkg::CountFull)
                          ? cc20_pkg::CountFull : in_byte_count;
    push_item.last      = in_last_word;
    push_item.new_msg   = !in_msg_r;
    push_item.new_block = (cur_pos == 4'd0);
    push_item.pos       = cur_pos;
  end

  // Advance position on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 4'd0;
      in_msg_r <= 1'b0;
    end else if (push) begin
      pos_r    <= pos_nxt;
      in_msg_r <= !in_last_word;
    end
  end

endmodule

`default_nettype wire

FILE: design/cc20_queue.sv
// Short queue between the front and back ends.
`default_nettype none

module cc20_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cc20_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output cc20_pkg::item_t       head_item
);

  cc20_pkg::item_t entry_r [cc20_pkg::QueueDepth];
  cc20_pkg::qptr_t wr_ptr_r;
  cc20_pkg::qptr_t rd_ptr_r;
  cc20_pkg::qcnt_t fill_r;

  assign full       = (fill_r == cc20_pkg::qcnt_t'(cc20_pkg::QueueDepth));
  assign head_valid = (fill_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= cc20_pkg::qptr_t'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= cc20_pkg::qptr_t'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        fill_r <= cc20_pkg::qcnt_t'(fill_r + 1'b1);
      end else if (pop && !push) begin
        fill_r <= cc20_pkg::qcnt_t'(fill_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cc20_back.sv
// Back end: keystream block generator, keystream store and result register.
`default_nettype none

module cc20_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cc20_pkg::cfg_t   cfg,
  input  wire logic             q_valid,
  input  wire cc20_pkg::item_t  q_head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [31:0]           out_result_word,
  output logic [2:0]            out_result_count,
  output logic                  out_result_last
);

  cc20_pkg::bk_state_t state_r;
  cc20_pkg::bk_state_t state_nxt;
  cc20_pkg::step_t     step_r;
  logic                done_r;
  cc20_pkg::word_t     ctr_r;
  cc20_pkg::word_t     cur_ctr_r;
  cc20_pkg::word_t     ctr_sel;
  cc20_pkg::word_t     ks_r   [cc20_pkg::BlockWords];
  cc20_pkg::word_t     ks_nxt [cc20_pkg::BlockWords];
  cc20_pkg::word_t     rnd    [cc20_pkg::BlockWords];

  logic                out_valid_r;
  cc20_pkg::word_t     out_word_r;
  logic [2:0]          out_count_r;
  logic                out_last_r;

  logic                slot_free;
  logic                emit;
  logic                start;
  logic                diag;
  logic                half;

  assign slot_free = !out_valid_r || !out_stall;
  assign diag      = step_r[1];
  assign half      = step_r[0];
  assign ctr_sel   = q_head.new_msg ? cfg.start_ctr : ctr_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cc20_pkg::BK_IDLE: begin
        if (q_valid && q_head.new_block && !done_r) begin
          state_nxt = cc20_pkg::BK_ROUND;
        end
      end
      cc20_pkg::BK_ROUND: begin
        if (step_r == cc20_pkg::LastStep) begin
          state_nxt = cc20_pkg::BK_FINAL;
        end
      end
      cc20_pkg::BK_FINAL: state_nxt = cc20_pkg::BK_IDLE;
      default:            state_nxt = cc20_pkg::BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    start = 1'b0;
    emit  = 1'b0;
    case (state_r)
      cc20_pkg::BK_IDLE: begin
        start = q_valid && q_head.new_block && !done_r;
        emit  = q_valid && (!q_head.new_block || done_r) && slot_free;
      end
      default: begin
        start = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  assign pop = emit;

  // One half step of four quarter rounds, column or diagonal
  always_comb begin
    logic [1:0]      lb;
    logic [1:0]      lc;
    logic [1:0]      ld;
    logic [3:0]      ix_a;
    logic [3:0]      ix_b;
    logic [3:0]      ix_c;
    logic [3:0]      ix_d;
    cc20_pkg::qr4_t  q;
    rnd = ks_r;
    for (int i = 0; i < cc20_pkg::Lanes; i++) begin
      lb   = 2'(i) + {1'b0, diag};
      lc   = 2'(i) + {diag, 1'b0};
      ld   = 2'(i) + {diag, diag};
      ix_a = {2'b00, 2'(i)};
      ix_b = {2'b01, lb};
      ix_c = {2'b10, lc};
      ix_d = {2'b11, ld};
      q.a  = ks_r[ix_a];
      q.b  = ks_r[ix_b];
      q.c  = ks_r[ix_c];
      q.d  = ks_r[ix_d];
      q    = cc20_pkg::qr_half(q, half);
      rnd[ix_a] = q.a;
      rnd[ix_b] = q.b;
      rnd[ix_c] = q.c;
      rnd[ix_d] = q.d;
    end
  end

  // Load, round or feed forward the block state
  always_comb begin
    ks_nxt = ks_r;
    if (start) begin
      for (int i = 0; i < cc20_pkg::BlockWords; i++) begin
        ks_nxt[i] = cc20_pkg::init_word(cfg, ctr_sel, 4'(i));
      end
    end else if (state_r == cc20_pkg::BK_ROUND) begin
      ks_nxt = rnd;
    end else if (state_r == cc20_pkg::BK_FINAL) begin
      for (int i = 0; i < cc20_pkg::BlockWords; i++) begin
        ks_nxt[i] = ks_r[i] + cc20_pkg::init_word(cfg, cur_ctr_r, 4'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cc20_pkg::BlockWords; i++) begin
      ks_r[i] <= ks_nxt[i];
    end
    if (start) begin
      cur_ctr_r <= ctr_sel;
    end
  end

  // Sequencer and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cc20_pkg::BK_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
      ctr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cc20_pkg::BK_ROUND) begin
        step_r <= cc20_pkg::step_t'(step_r + 1'b1);
      end else begin
        step_r <= '0;
      end
      if (start) begin
        ctr_r <= ctr_sel + 32'd1;
      end
      if (state_r == cc20_pkg::BK_FINAL) begin
        done_r <= 1'b1;
      end else if (emit) begin
        done_r <= 1'b0;
      end
    end
  end

  // Result register: hold while stalled, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r  <= (q_head.data ^ ks_r[q_head.pos]) & cc20_pkg::byte_mask(q_head.count);
      out_count_r <= q_head.count;
      out_last_r  <= q_head.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_word  = out_word_r;
  assign out_result_count = out_count_r;
  assign out_result_last  = out_last_r;

endmodule

`default_nettype wire

FILE: design/cc20_checker.sv
// Port-level checker of the cipher's result channel, bound to the top level.
`default_nettype none
`include "chacha20_stream_cipher_assert.svh"

module cc20_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_result_word,
  input wire logic [2:0]  out_result_count,
  input wire logic        out_result_last
);

  logic [35:0] out_bus;
  logic        lanes_ok;

  assign out_bus = {out_result_word, out_result_count, out_result_last};

  // Count is in range and unused byte lanes are zero
  always_comb begin
    case (out_result_count)
      3'd1:    lanes_ok = (out_result_word[31:8] == 24'd0);
      3'd2:    lanes_ok = (out_result_word[31:16] == 16'd0);
      3'd3:    lanes_ok = (out_result_word[31:24] == 8'd0);
      3'd4:    lanes_ok = 1'b1;
      default: lanes_ok = 1'b0;
    endcase
  end

  // A stalled result stays offered
  `CC20_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)

  // A stalled result does not change
  `CC20_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_bus))

  // Offered results carry a legal count and clean lanes
  `CC20_ASSERT(a_out_lanes, clk, rst_n, out_valid |-> lanes_ok)

  // Reset drops any pending result
  `CC20_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid)

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_chacha20_stream_cipher.sv
// Self-checking testbench for the ChaCha20 stream cipher with its own keystream predictor.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher;

  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_WORDS   = 180;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } cipher_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_word;
  logic [2:0]  out_result_count;
  logic        out_result_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Predictor copy of the configuration and of the keystream state
  logic [31:0] key_w [8];
  logic [31:0] nonce_w [3];
  logic [31:0] start_w;
  logic [31:0] blk_ctr;
  logic [31:0] keystream [16];
  logic [31:0] mix [16];
  logic [3:0]  word_idx;
  bit          msg_open;

  cipher_result_t pending_results[$];
  cipher_result_t want;

  int          errors;
  int unsigned items_sent;
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  bit          long_hold;

  chacha20_stream_cipher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .in_byte_count    (in_byte_count),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_word  (out_result_word),
    .out_result_count (out_result_count),
    .out_result_last  (out_result_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous bound
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void quarter_mix(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
  endfunction

  // Build one 16-word keystream block for the given counter
  function automatic void refill_keystream(input logic [31:0] ctr);
    logic [31:0] init_w [16];
    init_w[0] = SIGMA_0;
    init_w[1] = SIGMA_1;
    init_w[2] = SIGMA_2;
    init_w[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) init_w[4 + i] = key_w[i];
    init_w[12] = ctr;
    for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_w[i];
    for (int i = 0; i < 16; i++) mix[i] = init_w[i];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      quarter_mix(0, 4, 8, 12);
      quarter_mix(1, 5, 9, 13);
      quarter_mix(2, 6, 10, 14);
      quarter_mix(3, 7, 11, 15);
      quarter_mix(0, 5, 10, 15);
      quarter_mix(1, 6, 11, 12);
      quarter_mix(2, 7, 8, 13);
      quarter_mix(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) keystream[i] = mix[i] + init_w[i];
  endfunction

  // Work out the result of one accepted word and queue it
  function automatic void predict_transfer(input logic [31:0] d, input logic [2:0] c,
                                           input logic l);
    cipher_result_t r;
    logic [2:0]     n;
    logic [31:0]    mask;
    n = (c == 3'd0 || c > cc20_pkg::CountFull) ? cc20_pkg::CountFull : c;
    if (!msg_open) begin
      blk_ctr  = start_w;
      word_idx = 4'd0;
      msg_open = 1'b1;
    end
    if (word_idx == 4'd0) begin
      refill_keystream(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
    end
    mask    = (n == cc20_pkg::CountFull) ? 32'hffff_ffff : ((32'h1 << (8 * n)) - 32'h1);
    r.word  = (d ^ keystream[word_idx]) & mask;
    r.count = n;
    r.last  = l;
    word_idx = word_idx + 4'd1;
    if (l) msg_open = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Offer one word after a random gap and hold it until the transfer
  task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data_word  = d;
    in_byte_count = c;
    in_last_word  = l;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_transfer(d, c, l);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cc20_pkg::cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cc20_pkg::REG_KEY01:   begin key_w[0] = val[31:0]; key_w[1] = val[63:32]; end
      cc20_pkg::REG_KEY23:   begin key_w[2] = val[31:0]; key_w[3] = val[63:32]; end
      cc20_pkg::REG_KEY45:   begin key_w[4] = val[31:0]; key_w[5] = val[63:32]; end
      cc20_pkg::REG_KEY67:   begin key_w[6] = val[31:0]; key_w[7] = val[63:32]; end
      cc20_pkg::REG_NONCE01: begin nonce_w[0] = val[31:0]; nonce_w[1] = val[63:32]; end
      cc20_pkg::REG_NONCE2:  nonce_w[2] = val[31:0];
      cc20_pkg::REG_START:   start_w = val[31:0];
      default:     ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load key, nonce and start counter; upper halves of 32-bit registers carry junk
  task automatic apply_settings(input logic [255:0] key, input logic [95:0] nonce,
                                input logic [31:0] start);
    drain_results();
    cfg_write(cc20_pkg::REG_KEY01, key[63:0]);
    cfg_write(cc20_pkg::REG_KEY23, key[127:64]);
    cfg_write(cc20_pkg::REG_KEY45, key[191:128]);
    cfg_write(cc20_pkg::REG_KEY67, key[255:192]);
    cfg_write(cc20_pkg::REG_NONCE01, nonce[63:0]);
    cfg_write(cc20_pkg::REG_NONCE2, {$urandom, nonce[95:64]});
    cfg_write(cc20_pkg::REG_START, {$urandom, start});
  endtask

  // Mostly well-formed messages; now and then one with odd counts and early ends
  task automatic send_random_message();
    int unsigned len;
    bit          noisy;
    logic [2:0]  cnt;
    logic        fin;
    len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    noisy = ($urandom_range(0, 7) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      fin = (i == len - 1);
      cnt = fin ? 3'($urandom_range(1, 4)) : cc20_pkg::CountFull;
      if (noisy) begin
        cnt = 3'($urandom_range(0, 7));
        fin = fin | ($urandom_range(0, 9) == 0);
      end
      send_word($urandom, cnt, fin);
    end
  endtask

  // Lane masks, out-of-range counts and a partial word inside a message
  task automatic test_lane_masks();
    send_word(32'h0000_0000, 3'd1, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0);
    send_word(32'h0000_0000, 3'd3, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b0);
    send_word(32'ha5a5_5a5a, 3'd0, 1'b0);
    send_word(32'h5a5a_a5a5, 3'd5, 1'b0);
    send_word(32'hffff_ffff, 3'd6, 1'b0);
    send_word(32'h0000_0000, 3'd7, 1'b1);
  endtask

  // Counter wrap across a block boundary, with register writes inside the message
  task automatic test_wrap_and_midwrite();
    apply_settings({256{1'b1}}, {96{1'b1}}, 32'hffff_ffff);
    for (int i = 0; i < 10; i++) send_word($urandom, cc20_pkg::CountFull, 1'b0);
    drain_results();
    cfg_write(cc20_pkg::REG_KEY01, 64'h0);
    cfg_write(cc20_pkg::REG_KEY67, 64'h0);
    cfg_write(cc20_pkg::REG_START, 64'h5);
    for (int i = 0; i < 7; i++) send_word($urandom, cc20_pkg::CountFull, i == 6);
    send_word($urandom, cc20_pkg::CountFull, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
  endtask

  // Long receiver hold while words keep coming, then pause until all results are in
  task automatic test_backpressure();
    drain_results();
    in_gap_max = 0;
    long_hold  = 1'b1;
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 20; i++) send_word($urandom, cc20_pkg::CountFull, i == 19);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned in_caps [6]  = '{0, 15, 3, 0, 15, 7};
    int unsigned out_caps [6] = '{0, 15, 0, 15, 3, 7};
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings('0, '0, 32'h0);
        1: apply_settings({256{1'b1}}, {96{1'b1}}, 32'hffff_ffff);
        3: apply_settings({8{$urandom}}, {3{$urandom}}, 32'hffff_fff8 | $urandom_range(0, 7));
        default: apply_settings({8{$urandom}}, {3{$urandom}}, $urandom);
      endcase
      in_gap_max  = in_caps[p];
      out_gap_max = out_caps[p];
      first = items_sent;
      while (items_sent - first < PHASE_WORDS) send_random_message();
      if (p == 2) test_backpressure();
    end
  endtask

  // Receiver: stall a random number of cycles, or hold long when asked, then take one result
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        n = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(0, out_gap_max);
      end
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: result_word %h", out_result_word);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_word !== want.word) begin
          $error("result_word: expected %h, actual %h", want.word, out_result_word);
          errors++;
        end
        if (out_result_count !== want.count) begin
          $error("result_count: expected %0d, actual %0d", want.count, out_result_count);
          errors++;
        end
        if (out_result_last !== want.last) begin
          $error("result_last: expected %0d, actual %0d", want.last, out_result_last);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    in_valid      = 1'b0;
    in_data_word  = '0;
    in_byte_count = cc20_pkg::CountFull;
    in_last_word  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = cc20_pkg::REG_KEY01;
    cfg_data      = '0;
    for (int i = 0; i < 8; i++) key_w[i] = '0;
    for (int i = 0; i < 3; i++) nonce_w[i] = '0;
    start_w     = 32'd1;
    blk_ctr     = '0;
    word_idx    = '0;
    msg_open    = 1'b0;
    errors      = 0;
    items_sent  = 0;
    in_gap_max  = 15;
    out_gap_max = 15;
    long_hold   = 1'b0;
    rst_n       = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_lane_masks();
    test_wrap_and_midwrite();
    test_random_traffic();

    drain_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/cc20_pkg.sv
design/cc20_front.sv
design/cc20_queue.sv
design/cc20_back.sv
design/chacha20_stream_cipher.sv
design/cc20_checker.sv
tb/sv/tb_chacha20_stream_cipher.sv
